// ===== sv/ufcc_pkg.sv =====
// Shared types, codes and the microprogram of the union-find component counter.
`default_nettype none

package ufcc_pkg;

    localparam int NODES_DEFAULT = 32;
    localparam int IDX_SPAN      = 32;   // values an input node index can carry
    localparam int STEP_W        = 5;

    localparam logic [1:0] OP_UNION = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;
    localparam logic [1:0] OP_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] node_a;
        logic [4:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic [4:0] root;
        logic [5:0] set_size;
        logic       merged;
        logic [5:0] component_count;
    } out_item_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_CLR     = 5'd0;
    localparam step_t STEP_FETCH   = 5'd1;
    localparam step_t STEP_MARK_A  = 5'd2;
    localparam step_t STEP_MARK_B  = 5'd3;
    localparam step_t STEP_FIND_A0 = 5'd4;
    localparam step_t STEP_FIND_A1 = 5'd5;
    localparam step_t STEP_COMP_A0 = 5'd6;
    localparam step_t STEP_COMP_A1 = 5'd7;
    localparam step_t STEP_BR_OP   = 5'd8;
    localparam step_t STEP_FIND_B0 = 5'd9;
    localparam step_t STEP_FIND_B1 = 5'd10;
    localparam step_t STEP_COMP_B0 = 5'd11;
    localparam step_t STEP_COMP_B1 = 5'd12;
    localparam step_t STEP_SZ0     = 5'd13;
    localparam step_t STEP_SZ1     = 5'd14;
    localparam step_t STEP_SZ2     = 5'd15;
    localparam step_t STEP_LINK    = 5'd16;
    localparam step_t STEP_SZF0    = 5'd17;
    localparam step_t STEP_SZF1    = 5'd18;
    localparam step_t STEP_CNT0    = 5'd19;
    localparam step_t STEP_CNT1    = 5'd20;
    localparam step_t STEP_CNT2    = 5'd21;
    localparam step_t STEP_EMIT    = 5'd22;

    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_CLEAR      = 4'd1,
        ACT_LOAD       = 4'd2,
        ACT_MARK       = 4'd3,
        ACT_START      = 4'd4,
        ACT_WALK       = 4'd5,
        ACT_COMPRESS   = 4'd6,
        ACT_SIZE_RA    = 4'd7,
        ACT_SIZE_RB    = 4'd8,
        ACT_SIZE_LATCH = 4'd9,
        ACT_LINK       = 4'd10,
        ACT_FIND_RES   = 4'd11,
        ACT_SCAN_START = 4'd12,
        ACT_SCAN       = 4'd13,
        ACT_COUNT_RES  = 4'd14,
        ACT_EMIT       = 4'd15
    } act_t;

    typedef enum logic {
        SEL_A = 1'b0,
        SEL_B = 1'b1
    } sel_t;

    typedef enum logic [3:0] {
        J_NEXT     = 4'd0,
        J_ALWAYS   = 4'd1,
        J_DISPATCH = 4'd2,
        J_EMIT     = 4'd3,
        J_IF_MARK  = 4'd4,
        J_IF_FIND  = 4'd5,
        J_NOT_ROOT = 4'd6,
        J_NOT_DONE = 4'd7,
        J_NOT_LAST = 4'd8
    } jmp_t;

    typedef struct packed {
        logic  in_ready;
        act_t  act;
        sel_t  sel;
        jmp_t  jmp;
        step_t target;
    } cw_t;

    typedef struct packed {
        logic       at_root;
        logic       path_done;
        logic       ptr_last;
        logic       out_free;
        logic [1:0] op;
    } dp_status_t;

    function automatic cw_t mk(input logic rdy, input act_t a, input sel_t s,
                               input jmp_t j, input step_t t);
        cw_t w;
        w.in_ready = rdy;
        w.act      = a;
        w.sel      = s;
        w.jmp      = j;
        w.target   = t;
        return w;
    endfunction

    // Microprogram: one control word per step.
    function automatic cw_t ucode_word(input step_t s);
        cw_t w;
        case (s)
            STEP_CLR:     w = mk(1'b0, ACT_CLEAR,      SEL_A, J_NOT_LAST, STEP_CLR);
            STEP_FETCH:   w = mk(1'b1, ACT_LOAD,       SEL_A, J_DISPATCH, STEP_FETCH);
            STEP_MARK_A:  w = mk(1'b0, ACT_MARK,       SEL_A, J_IF_MARK,  STEP_EMIT);
            STEP_MARK_B:  w = mk(1'b0, ACT_MARK,       SEL_B, J_NEXT,     STEP_FIND_A0);
            STEP_FIND_A0: w = mk(1'b0, ACT_START,      SEL_A, J_NEXT,     STEP_FIND_A1);
            STEP_FIND_A1: w = mk(1'b0, ACT_WALK,       SEL_A, J_NOT_ROOT, STEP_FIND_A1);
            STEP_COMP_A0: w = mk(1'b0, ACT_START,      SEL_A, J_NEXT,     STEP_COMP_A1);
            STEP_COMP_A1: w = mk(1'b0, ACT_COMPRESS,   SEL_A, J_NOT_DONE, STEP_COMP_A1);
            STEP_BR_OP:   w = mk(1'b0, ACT_NONE,       SEL_A, J_IF_FIND,  STEP_SZF0);
            STEP_FIND_B0: w = mk(1'b0, ACT_START,      SEL_B, J_NEXT,     STEP_FIND_B1);
            STEP_FIND_B1: w = mk(1'b0, ACT_WALK,       SEL_B, J_NOT_ROOT, STEP_FIND_B1);
            STEP_COMP_B0: w = mk(1'b0, ACT_START,      SEL_B, J_NEXT,     STEP_COMP_B1);
            STEP_COMP_B1: w = mk(1'b0, ACT_COMPRESS,   SEL_B, J_NOT_DONE, STEP_COMP_B1);
            STEP_SZ0:     w = mk(1'b0, ACT_SIZE_RA,    SEL_A, J_NEXT,     STEP_SZ1);
            STEP_SZ1:     w = mk(1'b0, ACT_SIZE_RB,    SEL_A, J_NEXT,     STEP_SZ2);
            STEP_SZ2:     w = mk(1'b0, ACT_SIZE_LATCH, SEL_A, J_NEXT,     STEP_LINK);
            STEP_LINK:    w = mk(1'b0, ACT_LINK,       SEL_A, J_ALWAYS,   STEP_EMIT);
            STEP_SZF0:    w = mk(1'b0, ACT_SIZE_RA,    SEL_A, J_NEXT,     STEP_SZF1);
            STEP_SZF1:    w = mk(1'b0, ACT_FIND_RES,   SEL_A, J_ALWAYS,   STEP_EMIT);
            STEP_CNT0:    w = mk(1'b0, ACT_SCAN_START, SEL_A, J_NEXT,     STEP_CNT1);
            STEP_CNT1:    w = mk(1'b0, ACT_SCAN,       SEL_A, J_NOT_LAST, STEP_CNT1);
            STEP_CNT2:    w = mk(1'b0, ACT_COUNT_RES,  SEL_A, J_NEXT,     STEP_EMIT);
            STEP_EMIT:    w = mk(1'b0, ACT_EMIT,       SEL_A, J_EMIT,     STEP_FETCH);
            default:      w = mk(1'b0, ACT_NONE,       SEL_A, J_ALWAYS,   STEP_FETCH);
        endcase
        return w;
    endfunction

    // Entry step of each operation.
    function automatic step_t dispatch_target(input logic [1:0] opcode);
        step_t t;
        case (opcode)
            OP_UNION: t = STEP_MARK_A;
            OP_MARK:  t = STEP_MARK_A;
            OP_FIND:  t = STEP_FIND_A0;
            OP_COUNT: t = STEP_CNT0;
            default:  t = STEP_FETCH;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ufcc_chan_if.sv =====
// Valid/ready channel carrying one transaction payload.
`default_nettype none

interface ufcc_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ufcc_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none

module ufcc_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_opcode,
    input  ufcc_pkg::dp_status_t  st,
    output ufcc_pkg::cw_t         cw
);
    import ufcc_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    step_t upc_inc;
    cw_t   cw_cur;
    logic  accept;

    assign cw_cur  = ucode_word(upc_reg);
    assign cw      = cw_cur;
    assign accept  = in_valid & cw_cur.in_ready;
    assign upc_inc = upc_reg + STEP_W'(1);

    always_comb
    begin
        case (cw_cur.jmp)
            J_NEXT:     upc_next = upc_inc;
            J_ALWAYS:   upc_next = cw_cur.target;
            J_DISPATCH: upc_next = accept ? dispatch_target(in_opcode) : upc_reg;
            J_EMIT:     upc_next = st.out_free ? cw_cur.target : upc_reg;
            J_IF_MARK:  upc_next = (st.op == OP_MARK) ? cw_cur.target : upc_inc;
            J_IF_FIND:  upc_next = (st.op == OP_FIND) ? cw_cur.target : upc_inc;
            J_NOT_ROOT: upc_next = !st.at_root ? cw_cur.target : upc_inc;
            J_NOT_DONE: upc_next = !st.path_done ? cw_cur.target : upc_inc;
            J_NOT_LAST: upc_next = !st.ptr_last ? cw_cur.target : upc_inc;
            default:    upc_next = upc_inc;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ufcc_dpath.sv =====
// Datapath: node tables, walk pointer, root and size registers, result slot.
`default_nettype none

module ufcc_dpath #(
    parameter int NODES = ufcc_pkg::NODES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ufcc_pkg::cw_t         cw,
    input  logic                  accept,
    input  ufcc_pkg::in_item_t    in_item,
    input  logic                  out_ready,
    output logic                  out_valid,
    output ufcc_pkg::out_item_t   out_item,
    output ufcc_pkg::dp_status_t  st
);
    import ufcc_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int SW = $clog2(NODES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

    typedef logic [IW-1:0] idx_t;
    typedef logic [SW-1:0] cnt_t;

    idx_t parent_mem [NODES];
    cnt_t size_mem   [NODES];
    logic used_mem   [NODES];

    idx_t idx_fold [IDX_SPAN];

    logic [1:0] op_reg, op_next;
    idx_t       a_reg, a_next;
    idx_t       b_reg, b_next;
    idx_t       ptr_reg, ptr_next;
    idx_t       ra_reg, ra_next;
    idx_t       rb_reg, rb_next;
    cnt_t       sa_reg, sa_next;
    cnt_t       sb_reg, sb_next;
    cnt_t       cnt_reg, cnt_next;
    out_item_t  res_reg, res_next;
    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    idx_t prd_reg;
    cnt_t srd_reg;
    logic urd_reg;

    idx_t paddr;
    idx_t saddr;
    logic pwe, swe, uwe;
    idx_t pwa, swa, uwa;
    idx_t pwd;
    cnt_t swd;
    logic uwd;

    idx_t node_sel;
    idx_t root_sel;
    idx_t ptr_step;
    idx_t winner;
    idx_t loser;
    cnt_t size_sum;
    logic at_root;
    logic path_done;
    logic ptr_last;
    logic out_free;

    function automatic logic [5:0] sat6(input cnt_t v);
        if (32'(v) > 32'd63)
        begin
            return 6'd63;
        end
        return 6'(v);
    endfunction

    // Fold an input index into the table range.
    for (genvar g = 0; g < IDX_SPAN; g++)
    begin : g_fold
        assign idx_fold[g] = IW'(g % NODES);
    end

    assign node_sel  = (cw.sel == SEL_B) ? b_reg : a_reg;
    assign root_sel  = (cw.sel == SEL_B) ? rb_reg : ra_reg;
    assign at_root   = (prd_reg == ptr_reg);
    assign path_done = (ptr_reg == root_sel);
    assign ptr_last  = (ptr_reg == LAST_IDX);
    assign ptr_step  = ptr_last ? '0 : ptr_reg + IW'(1);
    assign winner    = (sa_reg >= sb_reg) ? ra_reg : rb_reg;
    assign loser     = (sa_reg >= sb_reg) ? rb_reg : ra_reg;
    assign size_sum  = sa_reg + sb_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign st.at_root   = at_root;
    assign st.path_done = path_done;
    assign st.ptr_last  = ptr_last;
    assign st.out_free  = out_free;
    assign st.op        = op_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ptr_next       = ptr_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        paddr          = ptr_reg;
        saddr          = ra_reg;
        pwe            = 1'b0;
        swe            = 1'b0;
        uwe            = 1'b0;
        pwa            = ptr_reg;
        swa            = ptr_reg;
        uwa            = ptr_reg;
        pwd            = ptr_reg;
        swd            = SW'(1);
        uwd            = 1'b0;

        // Drop the result once the sink has taken it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (cw.act)
            ACT_CLEAR:
            begin
                pwe      = 1'b1;
                swe      = 1'b1;
                uwe      = 1'b1;
                ptr_next = ptr_step;
            end
            ACT_LOAD:
            begin
                if (accept)
                begin
                    op_next  = in_item.opcode;
                    a_next   = idx_fold[in_item.node_a];
                    b_next   = idx_fold[in_item.node_b];
                    res_next = '0;
                end
            end
            ACT_MARK:
            begin
                uwe = 1'b1;
                uwa = node_sel;
                uwd = 1'b1;
            end
            ACT_START:
            begin
                ptr_next = node_sel;
                paddr    = node_sel;
            end
            ACT_WALK:
            begin
                if (!at_root)
                begin
                    ptr_next = prd_reg;
                    paddr    = prd_reg;
                end
                else if (cw.sel == SEL_B)
                begin
                    rb_next = ptr_reg;
                end
                else
                begin
                    ra_next = ptr_reg;
                end
            end
            ACT_COMPRESS:
            begin
                // Point the node at the root and advance along the old link.
                if (!path_done)
                begin
                    pwe      = 1'b1;
                    pwa      = ptr_reg;
                    pwd      = root_sel;
                    ptr_next = prd_reg;
                    paddr    = prd_reg;
                end
            end
            ACT_SIZE_RA:
            begin
                saddr = ra_reg;
            end
            ACT_SIZE_RB:
            begin
                sa_next = srd_reg;
                saddr   = rb_reg;
            end
            ACT_SIZE_LATCH:
            begin
                sb_next = srd_reg;
            end
            ACT_LINK:
            begin
                if (ra_reg != rb_reg)
                begin
                    pwe               = 1'b1;
                    pwa               = loser;
                    pwd               = winner;
                    swe               = 1'b1;
                    swa               = winner;
                    swd               = size_sum;
                    res_next.root     = 5'(winner);
                    res_next.set_size = sat6(size_sum);
                    res_next.merged   = 1'b1;
                end
                else
                begin
                    res_next.root     = 5'(ra_reg);
                    res_next.set_size = sat6(sa_reg);
                end
            end
            ACT_FIND_RES:
            begin
                res_next.root     = 5'(ra_reg);
                res_next.set_size = sat6(srd_reg);
            end
            ACT_SCAN_START:
            begin
                ptr_next = '0;
                paddr    = '0;
                cnt_next = '0;
            end
            ACT_SCAN:
            begin
                if (at_root && urd_reg)
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
                ptr_next = ptr_step;
                paddr    = ptr_step;
            end
            ACT_COUNT_RES:
            begin
                res_next.component_count = sat6(cnt_reg);
            end
            ACT_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            parent_mem[pwa] <= pwd;
        end
        prd_reg <= parent_mem[paddr];
    end

    always_ff @(posedge clk)
    begin
        if (swe)
        begin
            size_mem[swa] <= swd;
        end
        srd_reg <= size_mem[saddr];
    end

    always_ff @(posedge clk)
    begin
        if (uwe)
        begin
            used_mem[uwa] <= uwd;
        end
        urd_reg <= used_mem[paddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== sv/union_find_component_counter_core.sv =====
// Top level of the union-find component counter.
// Disjoint-set engine over NODES nodes (union by size, path compression), run by
// a microcoded sequencer over parent, size and used-flag tables, each with one
// read and one write port. After reset the block initialises the tables and takes
// no transaction until done. Find and union time is set by the one-node-per-cycle
// walk and compress loops on the parent table read port; count by the scan of
// that table. A finished result waits in the output register, and the block
// takes the next transaction meanwhile; it stalls in its final step only while
// an earlier result is still untaken.
`default_nettype none

module union_find_component_counter_core #(
    parameter int NODES = ufcc_pkg::NODES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ufcc_chan_if.sink    in_ch,
    ufcc_chan_if.source  out_ch
);
    import ufcc_pkg::*;

    cw_t        cw;
    dp_status_t st;
    logic       accept;
    logic       out_valid;
    out_item_t  out_data;

    assign in_ch.ready = cw.in_ready;
    assign accept      = in_ch.valid & cw.in_ready;

    ufcc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.data.opcode),
        .st        (st),
        .cw        (cw)
    );

    ufcc_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .accept    (accept),
        .in_item   (in_ch.data),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_item  (out_data),
        .st        (st)
    );

    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_data;

endmodule

`default_nettype wire

// ===== sim/union_find_component_counter_core_test.sv =====
// Self-checking test of the union-find component counter core.
`timescale 1ns / 100ps

module union_find_component_counter_core_test;
    import ufcc_pkg::*;

    localparam int NODES           = NODES_DEFAULT;
    localparam int PHASE_OPS       = 232;
    localparam int RANDOM_OPS      = 4 * PHASE_OPS;
    localparam int SETTLE_CYCLES   = NODES + 8;

    // Disjoint-set tracker: mirrors the node tables and holds outcomes still due.
    class disjoint_set_tracker;
        int unsigned parent_of[NODES];
        int unsigned members[NODES];
        bit          in_use[NODES];
        out_item_t   due_outcomes[$];
        int          errors;
        int          unions;
        int          merges;
        int          finds;
        int          marks;
        int          counts;

        function new();
            for (int i = 0; i < NODES; i++)
            begin
                parent_of[i] = i;
                members[i]   = 1;
                in_use[i]    = 1'b0;
            end
            errors = 0;
            unions = 0;
            merges = 0;
            finds  = 0;
            marks  = 0;
            counts = 0;
        endfunction

        function logic [5:0] clip6(int unsigned v);
            return (v > 63) ? 6'd63 : v[5:0];
        endfunction

        // Walk to the root, then point every node on the path straight at it.
        function int unsigned root_of(int unsigned n);
            int unsigned r;
            int unsigned cur;
            int unsigned nxt;
            int unsigned steps;
            r = n;
            steps = 0;
            while (parent_of[r] != r && steps < NODES)
            begin
                r = parent_of[r] % NODES;
                steps++;
            end
            cur = n;
            steps = 0;
            while (cur != r && steps < NODES)
            begin
                nxt = parent_of[cur] % NODES;
                parent_of[cur] = r;
                cur = nxt;
                steps++;
            end
            return r;
        endfunction

        function void record_op(in_item_t it);
            out_item_t   res;
            int unsigned a;
            int unsigned b;
            int unsigned ra;
            int unsigned rb;
            int unsigned tally;
            res = '0;
            a = it.node_a % NODES;
            b = it.node_b % NODES;
            case (it.opcode)
                OP_UNION:
                begin
                    unions++;
                    in_use[a] = 1'b1;
                    in_use[b] = 1'b1;
                    ra = root_of(a);
                    rb = root_of(b);
                    if (ra == rb)
                    begin
                        res.root     = ra[4:0];
                        res.set_size = clip6(members[ra]);
                    end
                    else if (members[ra] >= members[rb])
                    begin
                        members[ra]  += members[rb];
                        parent_of[rb] = ra;
                        res.root      = ra[4:0];
                        res.set_size  = clip6(members[ra]);
                        res.merged    = 1'b1;
                        merges++;
                    end
                    else
                    begin
                        members[rb]  += members[ra];
                        parent_of[ra] = rb;
                        res.root      = rb[4:0];
                        res.set_size  = clip6(members[rb]);
                        res.merged    = 1'b1;
                        merges++;
                    end
                end
                OP_MARK:
                begin
                    marks++;
                    in_use[a] = 1'b1;
                end
                OP_FIND:
                begin
                    finds++;
                    ra = root_of(a);
                    res.root     = ra[4:0];
                    res.set_size = clip6(members[ra]);
                end
                OP_COUNT:
                begin
                    counts++;
                    tally = 0;
                    for (int i = 0; i < NODES; i++)
                        if (parent_of[i] == i && in_use[i])
                            tally++;
                    res.component_count = clip6(tally);
                end
                default:
                begin
                end
            endcase
            due_outcomes.push_back(res);
        endfunction

        function void check_outcome(out_item_t got);
            out_item_t want;
            if (due_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result root=%0d size=%0d merged=%0d count=%0d",
                         $time, got.root, got.set_size, got.merged, got.component_count);
                errors++;
                return;
            end
            want = due_outcomes.pop_front();
            if (got.root !== want.root)
            begin
                $display("%0t: root expected %0d, got %0d", $time, want.root, got.root);
                errors++;
            end
            if (got.set_size !== want.set_size)
            begin
                $display("%0t: set_size expected %0d, got %0d",
                         $time, want.set_size, got.set_size);
                errors++;
            end
            if (got.merged !== want.merged)
            begin
                $display("%0t: merged expected %0d, got %0d", $time, want.merged, got.merged);
                errors++;
            end
            if (got.component_count !== want.component_count)
            begin
                $display("%0t: component_count expected %0d, got %0d",
                         $time, want.component_count, got.component_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;

    disjoint_set_tracker tracker;

    ufcc_chan_if #(.payload_t(in_item_t))  in_ch ();
    ufcc_chan_if #(.payload_t(out_item_t)) out_ch ();

    union_find_component_counter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // Result side: check each transaction, then decide on the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_outcome(out_ch.data);
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic in_item_t op_item(logic [1:0] op, logic [4:0] a, logic [4:0] b);
        in_item_t it;
        it.opcode = op;
        it.node_a = a;
        it.node_b = b;
        return it;
    endfunction

    // Most unions draw from a pool that widens over the run, so merges keep happening.
    function automatic in_item_t random_op(int unsigned done);
        in_item_t    it;
        int unsigned pool;
        int unsigned pick;
        pool = 3 + (done * (NODES - 4)) / RANDOM_OPS;
        it.node_a = 5'($urandom_range(31));
        it.node_b = 5'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            it.opcode = OP_UNION;
            if ($urandom_range(4) != 0)
            begin
                it.node_a = 5'($urandom_range(pool));
                it.node_b = 5'($urandom_range(pool));
            end
        end
        else if (pick < 52)
            it.opcode = OP_MARK;
        else if (pick < 85)
            it.opcode = OP_FIND;
        else
            it.opcode = OP_COUNT;
        return it;
    endfunction

    task automatic push_op(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        tracker.record_op(it);
    endtask

    // Hold the sender until every outstanding result has been taken.
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_outcomes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_item_t   opening[$];
        int unsigned done;
        tracker      = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        opening = '{
            op_item(OP_COUNT, 5'd0,  5'd31),   // nothing used yet
            op_item(OP_FIND,  5'd0,  5'd0),
            op_item(OP_FIND,  5'd31, 5'd31),
            op_item(OP_MARK,  5'd31, 5'd31),
            op_item(OP_COUNT, 5'd31, 5'd0),
            op_item(OP_UNION, 5'd0,  5'd31),   // equal sizes: A's root wins
            op_item(OP_UNION, 5'd31, 5'd0),    // already joined
            op_item(OP_UNION, 5'd5,  5'd5),    // same node on both sides
            op_item(OP_UNION, 5'd1,  5'd2),
            op_item(OP_UNION, 5'd3,  5'd1),    // larger set on the B side
            op_item(OP_UNION, 5'd1,  5'd0),
            op_item(OP_FIND,  5'd31, 5'd0),    // two-step path, compressed
            op_item(OP_FIND,  5'd31, 5'd0),
            op_item(OP_UNION, 5'd21, 5'd10),
            op_item(OP_UNION, 5'd10, 5'd3),
            op_item(OP_MARK,  5'd0,  5'd0),
            op_item(OP_MARK,  5'd30, 5'd21),
            op_item(OP_COUNT, 5'd10, 5'd21),
            op_item(OP_FIND,  5'd10, 5'd31),
            op_item(OP_FIND,  5'd30, 5'd0),
            op_item(OP_COUNT, 5'd0,  5'd0)
        };
        foreach (opening[i])
            push_op(opening[i]);
        hold_until_drained();

        done = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 73;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 73;
                end
                default:
                begin
                    idle_pct  = 16;
                    stall_pct = 16;
                end
            endcase
            for (int k = 0; k < PHASE_OPS; k++)
            begin
                if ($urandom_range(63) == 0)
                    hold_until_drained();
                push_op(random_op(done));
                done++;
            end
            hold_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.due_outcomes.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, tracker.due_outcomes.size());
            tracker.errors++;
        end
        $display("Covered %0d unions (%0d merging), %0d finds, %0d marks, %0d counts,",
                 tracker.unions, tracker.merges, tracker.finds, tracker.marks, tracker.counts);
        $display("under free-running, sender-idle, receiver-stall and mixed pacing.");
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ufcc_pkg.sv
sv/ufcc_chan_if.sv
sv/ufcc_seq.sv
sv/ufcc_dpath.sv
sv/union_find_component_counter_core.sv
sim/union_find_component_counter_core_test.sv
